>>> rtl/pem_pkg.sv
// shared constants and types for the pulse energy meter
`timescale 1ns / 1ps
package pem_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 63;
    localparam int ENERGY_W = 63;
    localparam int POWER_W  = 59;
    localparam int CONST_W  = 32;
    localparam int SCALE_W  = 17;
    localparam int PROD_W   = TIME_W + SCALE_W;

    // divider sizing
    localparam int DIV_W = 64;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // event codes
    typedef enum logic [KIND_W-1:0] {
        K_PULSE     = 2'd0,
        K_READ      = 2'd1,
        K_SET_COUNT = 2'd2,
        K_SET_CONST = 2'd3
    } t_kind;

    // meter constants
    localparam logic [CONST_W-1:0]  DEFAULT_IMPULSES = 32'd3200;
    localparam logic [SCALE_W-1:0]  ENERGY_SCALE     = 17'd100000;
    localparam logic [DIV_W-1:0]    POWER_NUM        = 64'd360000000000000000;
    localparam logic [TIME_W-1:0]   STALE_SLACK_US   = 32'd500000;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX       = {ENERGY_W{1'b1}};

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/pem_if.sv
// event and result channel interfaces for the pulse energy meter
`timescale 1ns / 1ps
interface pem_evt_if;
    logic                          valid;
    logic                          ready;
    logic [pem_pkg::KIND_W-1:0]    kind;
    logic [pem_pkg::TIME_W-1:0]    now_us;
    logic [pem_pkg::VALUE_W-1:0]   value;

    modport source (output valid, kind, now_us, value, input ready);
    modport sink   (input valid, kind, now_us, value, output ready);
endinterface

interface pem_res_if;
    logic                          valid;
    logic                          ready;
    logic [pem_pkg::ENERGY_W-1:0]  energy;
    logic [pem_pkg::POWER_W-1:0]   active_power;
    logic                          power_live;

    modport source (output valid, energy, active_power, power_live, input ready);
    modport sink   (input valid, energy, active_power, power_live, output ready);
endinterface

>>> rtl/pem_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pem_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pem_pkg::t_div_req i_req,
    output pem_pkg::t_div_rsp o_rsp
);

    logic [pem_pkg::DIV_W-1:0] r_rem;
    logic [pem_pkg::DIV_W-1:0] r_quo;
    logic [pem_pkg::DIV_W-1:0] r_dsr;
    logic [pem_pkg::CNT_W-1:0] r_cnt;
    logic                      r_done;

    logic [pem_pkg::DIV_W:0]   shifted;
    logic [pem_pkg::DIV_W:0]   diff;
    logic                      fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[pem_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, r_dsr};
        fits    = ~diff[pem_pkg::DIV_W];
    end

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_dsr <= i_req.divisor;
                r_cnt <= pem_pkg::CNT_W'(pem_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_rem <= fits ? diff[pem_pkg::DIV_W-1:0] : shifted[pem_pkg::DIV_W-1:0];
                r_quo <= {r_quo[pem_pkg::DIV_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pem_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> rtl/pulse_energy_meter.sv
// top level of the pulse energy meter: event sequencer and meter state
//
//   channel   dir   modport            transfer moves
//   i_evt     in    pem_evt_if.sink    kind, now_us, value
//   o_res     out   pem_res_if.source  energy, active_power, power_live
//
// pulse, set-counter and zero set-constant events finish in idle; a read or nonzero
// set-constant uses one 64-bit restoring divider at one quotient bit per cycle: an
// energy pass for both and, only for a read with power live, a power pass
// i_evt.ready is high only while the sequencer is idle; a finished read result
// waits in the output register and new events are taken while it waits
// reset is synchronous active low and restores the meter state at once
`timescale 1ns / 1ps
module pulse_energy_meter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pem_evt_if.sink   i_evt,
    pem_res_if.source o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EDIV,
        S_EWAIT,
        S_PDIV,
        S_PWAIT,
        S_OUT
    } t_state;

    t_state                          r_state,      n_state;
    logic [pem_pkg::TIME_W-1:0]      r_total,      n_total;
    logic [pem_pkg::TIME_W-1:0]      r_base_mark,  n_base_mark;
    logic [pem_pkg::TIME_W-1:0]      r_last_edge,  n_last_edge;
    logic [pem_pkg::TIME_W-1:0]      r_period,     n_period;
    logic [pem_pkg::ENERGY_W-1:0]    r_offset,     n_offset;
    logic [pem_pkg::CONST_W-1:0]     r_imp,        n_imp;
    logic                            r_edge_seen,  n_edge_seen;
    logic                            r_is_read,    n_is_read;
    logic [pem_pkg::CONST_W-1:0]     r_const,      n_const;
    logic [pem_pkg::TIME_W-1:0]      r_now,        n_now;
    logic [pem_pkg::PROD_W-1:0]      r_prod,       n_prod;
    logic [pem_pkg::DIV_W-1:0]       r_den,        n_den;
    logic                            r_live,       n_live;
    logic [pem_pkg::ENERGY_W-1:0]    r_energy,     n_energy;
    logic [pem_pkg::POWER_W-1:0]     r_power,      n_power;
    logic                            r_out_valid,  n_out_valid;
    logic [pem_pkg::ENERGY_W-1:0]    r_out_energy, n_out_energy;
    logic [pem_pkg::POWER_W-1:0]     r_out_power,  n_out_power;
    logic                            r_out_live,   n_out_live;

    logic                            evt_accept;
    logic [pem_pkg::TIME_W-1:0]      pulses;
    logic [pem_pkg::TIME_W-1:0]      age;
    logic [pem_pkg::TIME_W-1:0]      limit;
    logic [pem_pkg::DIV_W-1:0]       energy_sum;
    logic [pem_pkg::ENERGY_W-1:0]    energy_sat;

    pem_pkg::t_div_req               div_req;
    pem_pkg::t_div_rsp               div_rsp;

    // shared divider
    pem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // divider operands by phase
    always_comb begin
        div_req.start    = (r_state == S_EDIV) || (r_state == S_PDIV);
        div_req.dividend = (r_state == S_EDIV)
                         ? {{(pem_pkg::DIV_W - pem_pkg::PROD_W){1'b0}}, r_prod}
                         : pem_pkg::POWER_NUM;
        div_req.divisor  = (r_state == S_EDIV)
                         ? {{(pem_pkg::DIV_W - pem_pkg::CONST_W){1'b0}}, r_imp}
                         : r_den;
    end

    // datapath terms
    always_comb begin
        evt_accept = i_evt.valid && (r_state == S_IDLE);
        pulses     = r_total - r_base_mark;
        age        = r_now - r_last_edge;
        limit      = r_period + {r_period[pem_pkg::TIME_W-2:0], 1'b0}
                   + pem_pkg::STALE_SLACK_US;
        energy_sum = {1'b0, r_offset}
                   + {{(pem_pkg::DIV_W - pem_pkg::PROD_W){1'b0}},
                      div_rsp.quotient[pem_pkg::PROD_W-1:0]};
        energy_sat = energy_sum[pem_pkg::DIV_W-1] ? pem_pkg::ENERGY_MAX
                                                  : energy_sum[pem_pkg::ENERGY_W-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_base_mark  = r_base_mark;
        n_last_edge  = r_last_edge;
        n_period     = r_period;
        n_offset     = r_offset;
        n_imp        = r_imp;
        n_edge_seen  = r_edge_seen;
        n_is_read    = r_is_read;
        n_const      = r_const;
        n_now        = r_now;
        n_prod       = r_prod;
        n_den        = r_den;
        n_live       = r_live;
        n_energy     = r_energy;
        n_power      = r_power;
        n_out_valid  = r_out_valid;
        n_out_energy = r_out_energy;
        n_out_power  = r_out_power;
        n_out_live   = r_out_live;

        // result register drains on transfer
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (evt_accept) begin
                    case (pem_pkg::t_kind'(i_evt.kind))
                        pem_pkg::K_PULSE: begin
                            if (r_edge_seen) begin
                                n_period = i_evt.now_us - r_last_edge;
                            end
                            n_last_edge = i_evt.now_us;
                            n_edge_seen = 1'b1;
                            n_total     = r_total + 1'b1;
                        end
                        pem_pkg::K_READ: begin
                            n_now     = i_evt.now_us;
                            n_is_read = 1'b1;
                            n_state   = S_MUL;
                        end
                        pem_pkg::K_SET_COUNT: begin
                            n_base_mark = r_total;
                            n_offset    = i_evt.value;
                        end
                        pem_pkg::K_SET_CONST: begin
                            if (i_evt.value[pem_pkg::CONST_W-1:0] != '0) begin
                                n_const   = i_evt.value[pem_pkg::CONST_W-1:0];
                                n_is_read = 1'b0;
                                n_state   = S_MUL;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                // scaled pulse count, power denominator, staleness check
                n_prod  = {{pem_pkg::SCALE_W{1'b0}}, pulses}
                        * {{pem_pkg::TIME_W{1'b0}}, pem_pkg::ENERGY_SCALE};
                n_den   = {{pem_pkg::TIME_W{1'b0}}, r_imp}
                        * {{pem_pkg::CONST_W{1'b0}}, r_period};
                n_live  = (r_period != '0) && (age < limit);
                n_state = S_EDIV;
            end
            S_EDIV: begin
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                if (div_rsp.done) begin
                    n_energy = energy_sat;
                    if (r_is_read) begin
                        if (r_live) begin
                            n_state = S_PDIV;
                        end else begin
                            n_power = '0;
                            n_state = S_OUT;
                        end
                    end else begin
                        // fold accrued energy into the base, then switch constant
                        n_offset    = energy_sat;
                        n_base_mark = r_total;
                        n_imp       = r_const;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_PDIV: begin
                n_state = S_PWAIT;
            end
            S_PWAIT: begin
                if (div_rsp.done) begin
                    n_power = div_rsp.quotient[pem_pkg::POWER_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_energy = r_energy;
                    n_out_power  = r_power;
                    n_out_live   = r_live;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_base_mark <= '0;
            r_last_edge <= '0;
            r_period    <= '0;
            r_offset    <= '0;
            r_imp       <= pem_pkg::DEFAULT_IMPULSES;
            r_edge_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_base_mark  <= n_base_mark;
            r_last_edge  <= n_last_edge;
            r_period     <= n_period;
            r_offset     <= n_offset;
            r_imp        <= n_imp;
            r_edge_seen  <= n_edge_seen;
            r_out_valid  <= n_out_valid;
            r_is_read    <= n_is_read;
            r_const      <= n_const;
            r_now        <= n_now;
            r_prod       <= n_prod;
            r_den        <= n_den;
            r_live       <= n_live;
            r_energy     <= n_energy;
            r_power      <= n_power;
            r_out_energy <= n_out_energy;
            r_out_power  <= n_out_power;
            r_out_live   <= n_out_live;
        end
    end

    // channel outputs
    assign i_evt.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.energy       = r_out_energy;
    assign o_res.active_power = r_out_power;
    assign o_res.power_live   = r_out_live;

endmodule

>>> rtl/pem_checker.sv
// port-level checks for the pulse energy meter, bound to the top level
`timescale 1ns / 1ps
module pem_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [pem_pkg::KIND_W-1:0]    i_in_kind,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [pem_pkg::ENERGY_W-1:0]  i_out_energy,
    input logic [pem_pkg::POWER_W-1:0]   i_out_power,
    input logic                          i_out_live
);

    // a waiting result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_energy)
            && $stable(i_out_power) && $stable(i_out_live))
        else $error("result dropped or changed while stalled");

    // a read keeps the meter busy for the divider passes
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == pem_pkg::K_READ) |=> !i_in_ready)
        else $error("ready after accepting a read");

    // only reads make results
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind != pem_pkg::K_READ) && !i_out_valid
            |=> !i_out_valid)
        else $error("result without a read");

    // no power reported unless live
    a_power_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_live |-> (i_out_power == '0))
        else $error("nonzero power with power_live low");

endmodule

bind pulse_energy_meter pem_checker u_pem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_evt.valid),
    .i_in_ready   (i_evt.ready),
    .i_in_kind    (i_evt.kind),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_energy (o_res.energy),
    .i_out_power  (o_res.active_power),
    .i_out_live   (o_res.power_live)
);
